// ----- design/tsb_pkg.sv -----
// shared types and constants for the texture sampler
`timescale 1ns / 1ps
package tsb_pkg;
   localparam int FRAC_BITS = 16;
   localparam int OUT_BITS = 16;

   typedef enum logic [1:0] {
      CSR_WIDTH = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FILTER = 2'd2
   } csr_index_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_SAMPLE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_WAIT,
      BK_MIX0,
      BK_MIX1,
      BK_DONE
   } back_state_type;
endpackage

// ----- design/tsb_ram.sv -----
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
module tsb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- design/tsb_front.sv -----
// front end: accepts commands, computes texel coordinates and weights
`timescale 1ns / 1ps
module tsb_front #(
   parameter int XW = 8,
   parameter int YW = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic                         command,
   input  logic [15:0]                  frac_u,
   input  logic [15:0]                  frac_v,
   input  logic [XW:0]                  width_eff,
   input  logic [YW:0]                  height_eff,
   input  logic                         filter_mode,
   output logic                         out_valid,
   output logic [2*(XW+YW)+2*tsb_pkg::FRAC_BITS:0] out_data
);
   import tsb_pkg::*;
   localparam int SUW = FRAC_BITS + XW + 1;
   localparam int SVW = FRAC_BITS + YW + 1;

   logic           valid_ff;
   logic           mode_ff;
   logic [SUW-1:0] su_ff;
   logic [SVW-1:0] sv_ff;
   logic [XW:0]    w_ff;
   logic [YW:0]    h_ff;
   logic [SUW-1:0] su_in;
   logic [SVW-1:0] sv_in;
   logic [SUW-1:0] ru;
   logic [SVW-1:0] rv;
   logic [XW:0]    ix, x0, x1;
   logic [YW:0]    iy, y0, y1;
   logic [15:0]    wx, wy;

   assign su_in = SUW'(frac_u) * SUW'(width_eff);
   assign sv_in = SVW'(frac_v) * SVW'(height_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid && command == CMD_SAMPLE;
      end
      su_ff <= su_in;
      sv_ff <= sv_in;
      mode_ff <= filter_mode;
      w_ff <= width_eff;
      h_ff <= height_eff;
   end

   always_comb begin
      ru = su_ff + SUW'(16'h8000);
      rv = sv_ff + SVW'(16'h8000);
      wx = su_ff[15:0];
      wy = sv_ff[15:0];
      if (mode_ff) begin
         x0 = su_ff[SUW-1:16];
         y0 = sv_ff[SVW-1:16];
         if (x0 >= w_ff) x0 = '0;
         if (y0 >= h_ff) y0 = '0;
         x1 = (wx == 16'd0) ? x0 : x0 + 1'b1;
         y1 = (wy == 16'd0) ? y0 : y0 + 1'b1;
         if (x1 >= w_ff) x1 = '0;
         if (y1 >= h_ff) y1 = '0;
      end else begin
         ix = ru[SUW-1:16];
         iy = rv[SVW-1:16];
         if (ix >= w_ff) ix = '0;
         if (iy >= h_ff) iy = '0;
         x0 = ix;
         x1 = ix;
         y0 = iy;
         y1 = iy;
         wx = '0;
         wy = '0;
      end
      if (!mode_ff) begin
         ix = '0;
         iy = '0;
      end else begin
         ix = '0;
         iy = '0;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = {mode_ff, x0[XW-1:0], x1[XW-1:0], y0[YW-1:0], y1[YW-1:0], wx, wy};
endmodule

// ----- design/tsb_back.sv -----
// back end: reads four texels and blends them, or reads one texel in nearest mode
`timescale 1ns / 1ps
module tsb_back #(
   parameter int XW = 8,
   parameter int YW = 8,
   parameter int CB = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  logic [2*(XW+YW)+2*tsb_pkg::FRAC_BITS:0] job_data,
   output logic                      job_take,
   output logic [XW+YW-1:0]          rd_addr,
   input  logic [3*CB-1:0]           rd_data,
   output logic                      rsp_valid,
   output logic [3*CB-1:0]           rsp_rgb
);
   import tsb_pkg::*;

   back_state_type state_ff, state_in;
   logic [2*(XW+YW)+2*FRAC_BITS:0] job_ff;
   logic [2:0] cnt_ff, cnt_in;
   logic [CB-1:0] t_ff [4][3];
   logic [CB-1:0] v_ff [2][3];
   logic [CB-1:0] r_ff [3];
   logic mode;
   logic [XW-1:0] x0, x1;
   logic [YW-1:0] y0, y1;
   logic [15:0] wx, wy;

   assign {mode, x0, x1, y0, y1, wx, wy} = job_ff;

   function automatic logic [CB-1:0] mix(input logic [CB-1:0] a, input logic [CB-1:0] b,
                                          input logic [15:0] w);
      logic [CB-1:0] d;
      logic [CB+15:0] p;
      begin
         d = (b >= a) ? b - a : a - b;
         p = (CB+16)'(d) * (CB+16)'(w);
         mix = (b >= a) ? a + p[CB+15:16] : a - p[CB+15:16];
      end
   endfunction

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: rd_addr = {y0, x0};
         2'd1: rd_addr = {y0, x1};
         2'd2: rd_addr = {y1, x0};
         default: rd_addr = {y1, x1};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      job_take = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               cnt_in = '0;
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            cnt_in = cnt_ff + 1'b1;
            if (!mode || cnt_ff == 3'd3) state_in = BK_WAIT;
         end
         BK_WAIT: state_in = mode ? BK_MIX0 : BK_DONE;
         BK_MIX0: state_in = BK_MIX1;
         BK_MIX1: state_in = BK_DONE;
         BK_DONE: state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      if (job_take) job_ff <= job_data;
      // read data lands in the cycle after its address
      if ((state_ff == BK_READ && cnt_ff != 3'd0) || state_ff == BK_WAIT) begin
         for (int c = 0; c < 3; c++) begin
            t_ff[(state_ff == BK_WAIT) ? cnt_ff[1:0] - 2'd1 : cnt_ff[1:0] - 2'd1][c]
               <= rd_data[c*CB +: CB];
         end
      end
      if (state_ff == BK_MIX0) begin
         for (int c = 0; c < 3; c++) begin
            v_ff[0][c] <= mix(t_ff[0][c], t_ff[1][c], wx);
            v_ff[1][c] <= mix(t_ff[2][c], t_ff[3][c], wx);
         end
      end
      if (state_ff == BK_MIX1) begin
         for (int c = 0; c < 3; c++) r_ff[c] <= mix(v_ff[0][c], v_ff[1][c], wy);
      end
   end

   assign rsp_valid = state_ff == BK_DONE;
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rsp_rgb[c*CB +: CB] = mode ? r_ff[c] : t_ff[0][c];
      end
   end
endmodule

// ----- design/texture_sampler_bilinear_wrap.sv -----
// top level of the wrap-mode bilinear texture sampler
//
// req_ channel: start with command, pixel and coordinate fields; taken when
// start is high and busy low. a write stores one texel if the pixel lies
// inside the image size and gives no result. a sample gives one rsp_ result,
// marked by rsp_valid for a single cycle; the receiver cannot stall it.
// front: scales the fraction by the image size into a register and picks texel
// coordinates from it; a two-entry queue holds the job; back: reads the texel
// store, one read per cycle through its single read port, then blends.
// path: front register, job queue, then back states read, wait, mix0 and mix1
// (bilinear only) and done, which raises rsp_valid.
// busy holds from an accepted sample until its result, so no transaction is
// taken while a sample is in flight; writes leave busy low and can follow
// back to back.
// csr_ channel: index 0 width, 1 height, 2 filter mode; the user writes it
// only while idle, which the block itself does not enforce. reset: registers
// go to 256, 256, nearest; texel store contents stay undefined until written.
`timescale 1ns / 1ps
module texture_sampler_bilinear_wrap #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   output logic        rsp_valid,
   output logic [15:0] rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tsb_pkg::*;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int CB = CHANNEL_BITS;
   localparam int JW = 2*(XW+YW)+2*FRAC_BITS+1;

   logic [8:0] width_ff, height_ff;
   logic       mode_ff;
   logic [XW:0] w_eff;
   logic [YW:0] h_eff;
   logic accept, wr_ok, job_valid, job_take, rsp_v;
   logic [JW-1:0] job_data;
   logic [JW-1:0] q_ff [2];
   logic [1:0] qcnt_ff;
   logic [XW+YW-1:0] rd_addr;
   logic [3*CB-1:0] rd_data, rgb;

   always_comb begin
      if (width_ff == 9'd0) w_eff = (XW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
      else w_eff = (XW+1)'(width_ff);
      if (height_ff == 9'd0) h_eff = (YW+1)'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
      else h_eff = (YW+1)'(height_ff);
   end

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 9'd256;
         height_ff <= 9'd256;
         mode_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH: width_ff <= csr_data[8:0];
            CSR_HEIGHT: height_ff <= csr_data[8:0];
            CSR_FILTER: mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign accept = start && !busy;
   assign wr_ok = accept && req_command == CMD_WRITE
      && 32'(req_pixel_x) < 32'(w_eff) && 32'(req_pixel_y) < 32'(h_eff);

   logic f_valid;
   tsb_front #(.XW(XW), .YW(YW)) u_front (
      .clock(clock), .reset(reset), .in_valid(accept), .command(req_command),
      .frac_u(req_tex_u[15:0]), .frac_v(req_tex_v[15:0]),
      .width_eff(w_eff), .height_eff(h_eff), .filter_mode(mode_ff),
      .out_valid(f_valid), .out_data(job_data)
   );

   // two-entry job queue
   always_ff @(posedge clock) begin
      if (reset) begin
         qcnt_ff <= '0;
      end else begin
         qcnt_ff <= qcnt_ff + 2'(f_valid) - 2'(job_take);
      end
      if (f_valid && (qcnt_ff - 2'(job_take)) == 2'd0) q_ff[0] <= job_data;
      else if (job_take) q_ff[0] <= q_ff[1];
      if (f_valid && (qcnt_ff - 2'(job_take)) != 2'd0) q_ff[1] <= job_data;
   end
   assign job_valid = qcnt_ff != 2'd0;

   // one sample in flight end to end
   logic inflight_ff;
   always_ff @(posedge clock) begin
      if (reset) inflight_ff <= 1'b0;
      else if (accept && req_command == CMD_SAMPLE) inflight_ff <= 1'b1;
      else if (rsp_v) inflight_ff <= 1'b0;
   end
   assign busy = inflight_ff;

   tsb_ram #(.WIDTH(3*CB), .DEPTH((2**XW)*(2**YW))) u_ram (
      .clock(clock), .wr_en(wr_ok),
      .wr_addr({YW'(req_pixel_y), XW'(req_pixel_x)}),
      .wr_data({CB'(req_blue_in), CB'(req_green_in), CB'(req_red_in)}),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   tsb_back #(.XW(XW), .YW(YW), .CB(CB)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job_data(q_ff[0]),
      .job_take(job_take), .rd_addr(rd_addr), .rd_data(rd_data),
      .rsp_valid(rsp_v), .rsp_rgb(rgb)
   );

   assign rsp_valid = rsp_v;
   assign rsp_red_out = 16'(rgb[0 +: CB]);
   assign rsp_green_out = 16'(rgb[CB +: CB]);
   assign rsp_blue_out = 16'(rgb[2*CB +: CB]);
endmodule

// ----- design/tsb_checker.sv -----
// port-level checks for the texture sampler
`timescale 1ns / 1ps
module tsb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_command,
   input logic rsp_valid
);
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command |=> busy) else $error("sample taken without busy");
   a_rsp_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without transaction");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
endmodule

bind texture_sampler_bilinear_wrap tsb_checker u_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_command(req_command), .rsp_valid(rsp_valid)
);

// ----- dv/tsb_checker.sv -----
// checker for the texture sampler: predicts every sample result and compares
`timescale 1ns / 1ps
module tsb_scoreboard
   import tsb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic        req_command,
   input  logic [7:0]  req_pixel_x,
   input  logic [7:0]  req_pixel_y,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic        rsp_valid,
   input  logic [15:0] rsp_red_out,
   input  logic [15:0] rsp_green_out,
   input  logic [15:0] rsp_blue_out,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          mismatches,
   output int          pending
);
   logic [47:0] texels [65536];
   logic [8:0]  width_reg, height_reg;
   logic        bilinear;
   logic [47:0] samples_due [$];

   function automatic logic [8:0] clamp_size(input logic [8:0] v);
      if (v == 0) return 9'd1;
      if (v > 9'd256) return 9'd256;
      return v;
   endfunction

   function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] w);
      logic [31:0] p;
      if (b >= a) begin
         p = 32'(b - a) * 32'(w);
         return a + p[31:16];
      end else begin
         p = 32'(a - b) * 32'(w);
         return a - p[31:16];
      end
   endfunction

   function automatic logic [47:0] texel_at(input logic [8:0] x, input logic [8:0] y);
      return texels[{y[7:0], x[7:0]}];
   endfunction

   function automatic logic [47:0] sample_color(input logic [15:0] fu, input logic [15:0] fv);
      logic [8:0]  w, h, x0, y0, x1, y1;
      logic [31:0] su, sv;
      logic [47:0] t00, t10, t01, t11, res;
      logic [15:0] v0, v1;
      w = clamp_size(width_reg);
      h = clamp_size(height_reg);
      su = 32'(fu) * 32'(w);
      sv = 32'(fv) * 32'(h);
      if (!bilinear) begin
         x0 = 9'((su + 32'h8000) >> 16);
         y0 = 9'((sv + 32'h8000) >> 16);
         if (x0 >= w) x0 = 0;
         if (y0 >= h) y0 = 0;
         return texel_at(x0, y0);
      end
      x0 = su[24:16];
      y0 = sv[24:16];
      if (x0 >= w) x0 = 0;
      if (y0 >= h) y0 = 0;
      x1 = (su[15:0] == 0) ? x0 : x0 + 9'd1;
      y1 = (sv[15:0] == 0) ? y0 : y0 + 9'd1;
      if (x1 >= w) x1 = 0;
      if (y1 >= h) y1 = 0;
      t00 = texel_at(x0, y0);
      t10 = texel_at(x1, y0);
      t01 = texel_at(x0, y1);
      t11 = texel_at(x1, y1);
      for (int c = 0; c < 3; c++) begin
         v0 = blend(t00[c*16 +: 16], t10[c*16 +: 16], su[15:0]);
         v1 = blend(t01[c*16 +: 16], t11[c*16 +: 16], su[15:0]);
         res[c*16 +: 16] = blend(v0, v1, sv[15:0]);
      end
      return res;
   endfunction

   assign pending = samples_due.size();

   always @(posedge clock) begin
      logic [47:0] want;
      logic [8:0]  w, h;
      if (reset) begin
         width_reg <= 9'd256;
         height_reg <= 9'd256;
         bilinear <= 1'b0;
         samples_due.delete();
         mismatches <= 0;
      end else begin
         if (rsp_valid) begin
            if (samples_due.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result r=%h g=%h b=%h",
                           rsp_red_out, rsp_green_out, rsp_blue_out);
               mismatches <= mismatches + 1;
            end else begin
               want = samples_due.pop_front();
               if (want != {rsp_blue_out, rsp_green_out, rsp_red_out}) begin
                  if (mismatches < 10)
                     $display("result mismatch: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                              want[15:0], want[31:16], want[47:32],
                              rsp_red_out, rsp_green_out, rsp_blue_out);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (start && !busy) begin
            if (req_command == CMD_SAMPLE) begin
               samples_due.push_back(sample_color(req_tex_u[15:0], req_tex_v[15:0]));
            end else begin
               w = clamp_size(width_reg);
               h = clamp_size(height_reg);
               if ({1'b0, req_pixel_x} < w && {1'b0, req_pixel_y} < h)
                  texels[{req_pixel_y, req_pixel_x}] = {req_blue_in, req_green_in, req_red_in};
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDTH: width_reg <= csr_data[8:0];
               CSR_HEIGHT: height_reg <= csr_data[8:0];
               CSR_FILTER: bilinear <= csr_data[0];
               default: ;
            endcase
         end
      end
   end
endmodule

// ----- dv/texture_sampler_bilinear_wrap_tb.sv -----
// testbench top for the texture sampler: stimulus, configuration phases and verdict
`timescale 1ns / 1ps
module texture_sampler_bilinear_wrap_tb;
   import tsb_pkg::*;

   localparam logic [1:0] CSR_SPARE = 2'd3;
   localparam int STALL_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = CMD_WRITE;
   logic [7:0]  req_pixel_x = '0, req_pixel_y = '0;
   logic [15:0] req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic signed [31:0] req_tex_u = '0, req_tex_v = '0;
   logic        rsp_valid;
   logic [15:0] rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   int          mismatches, pending;
   int          stall_count = 0;

   bit          written [65536];
   int          eff_w = 256, eff_h = 256;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   texture_sampler_bilinear_wrap dut (.*);

   tsb_scoreboard u_scoreboard (.*);

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_count <= 0;
      else if (stall_count >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else
         stall_count <= stall_count + 1;
   end

   function automatic logic [15:0] pick_level();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 7))
         0: c[15:0] = 16'h0000;
         1: c[15:0] = 16'hffff;
         2: c[15:0] = 16'h8000;
         3: c[15:0] = 16'((($urandom_range(0, 255) * 65536) / 256) + $urandom_range(0, 2) - 1);
         default: ;
      endcase
      return c;
   endfunction

   task automatic issue(input command_type cmd, input logic [7:0] x, input logic [7:0] y,
                        input logic [31:0] u, input logic [31:0] v);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_pixel_x <= x;
      req_pixel_y <= y;
      req_red_in <= pick_level();
      req_green_in <= pick_level();
      req_blue_in <= pick_level();
      req_tex_u <= u;
      req_tex_v <= v;
      do @(posedge clock); while (busy);
      if (cmd == CMD_WRITE && x < eff_w && y < eff_h)
         written[{y, x}] = 1'b1;
   endtask

   task automatic store_texel(input int x, input int y);
      issue(CMD_WRITE, 8'(x), 8'(y), $urandom, $urandom);
   endtask

   task automatic sample(input logic [31:0] u, input logic [31:0] v);
      issue(CMD_SAMPLE, 8'($urandom), 8'($urandom), u, v);
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      start <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input bit bilin);
      logic [31:0] r;
      settle();
      r = $urandom;
      csr_write(CSR_WIDTH, {r[31:9], 9'(w)});
      r = $urandom;
      csr_write(CSR_HEIGHT, {r[31:9], 9'(h)});
      r = $urandom;
      csr_write(CSR_FILTER, {r[31:1], bilin});
      eff_w = (w == 0) ? 1 : (w > 256 ? 256 : w);
      eff_h = (h == 0) ? 1 : (h > 256 ? 256 : h);
      for (int y = 0; y < eff_h; y++)
         for (int x = 0; x < eff_w; x++)
            if (!written[y * 256 + x]) store_texel(x, y);
   endtask

   task automatic run_phase(input int w, input int h, input bit bilin, input int count);
      configure(w, h, bilin);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: store_texel($urandom_range(0, eff_w - 1), $urandom_range(0, eff_h - 1));
            3: store_texel($urandom_range(0, 255), $urandom_range(0, 255));
            default: sample(pick_coord(), pick_coord());
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero sizes act as one, ignored writes, spare index, coordinate extremes
      configure(0, 0, 1'b0);
      store_texel(5, 5);
      store_texel(255, 0);
      csr_write(CSR_SPARE, 32'hffff_ffff);
      sample(32'h8000_0000, 32'h7fff_ffff);
      sample(32'h0000_0000, 32'hffff_ffff);
      sample(32'h0000_8000, 32'h0000_7fff);
      configure(1, 1, 1'b1);
      sample(32'h7fff_ffff, 32'h8000_0000);
      sample(32'h0000_8000, 32'hffff_8000);
      configure(2, 2, 1'b1);
      sample(32'h0000_8000, 32'h0000_8000);
      sample(32'h0000_ffff, 32'h0000_ffff);
      sample(32'h0000_0000, 32'h0000_4000);
      configure(2, 2, 1'b0);
      sample(32'h0000_c000, 32'h0000_bfff);
      sample(32'h0000_7fff, 32'h0000_8000);

      run_phase(16, 16, 1'b1, 30);
      run_phase(16, 16, 1'b0, 25);
      run_phase(256, 1, 1'b1, 30);
      run_phase(256, 1, 1'b0, 25);
      run_phase(1, 256, 1'b1, 30);
      run_phase(511, 1, 1'b1, 20);
      run_phase(1, 300, 1'b0, 20);
      run_phase(7, 5, 1'b0, 25);
      run_phase(3, 13, 1'b1, 25);
      run_phase(16, 9, 1'b1, 25);
      run_phase(1, 1, 1'b1, 15);

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ----- filelist.f -----
design/tsb_pkg.sv
design/tsb_ram.sv
design/tsb_front.sv
design/tsb_back.sv
design/texture_sampler_bilinear_wrap.sv
design/tsb_checker.sv
dv/tsb_checker.sv
dv/texture_sampler_bilinear_wrap_tb.sv
